// ===== rtl/bsa_pkg.sv =====
package bsa_pkg;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 48;

  typedef enum logic [CfgIdxBits-1:0] {
    RegBlockSize    = 3'd0,
    RegBlockCount   = 3'd1,
    RegRegionBase   = 3'd2,
    RegRegionLength = 3'd3,
    RegDebugMode    = 3'd4,
    RegDebugBase    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StNone  = 2'd1,
    StRange = 2'd2,
    StFreed = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SMul,
    SAddr,
    SCheck,
    SDiv,
    SFree,
    SDone
  } state_e;

  typedef struct packed {
    logic        mode;
    logic [47:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] block_address;
  } rsp_t;

endpackage

// ===== rtl/bitmap_slab_allocator.sv =====
// Bitmap block allocator.
// Requests enter on start_i with req_i (mode 0 allocate, 1 free) when busy_o is
// low; busy_o rises the next cycle and stays high until the result is shown.
// Each result appears on rsp_o for exactly one cycle with done_o high; the
// receiver cannot stall, so it must take the result in that cycle. busy_o is
// already low in that cycle, so the next request can be taken at its end.
// An allocate scans the used map one 64-bit word per cycle through a priority
// encoder, then does the index multiply (a shift in debug mode) in SMul and the
// address add in SAddr; both are registered before the result shows.
// A free checks the region in SCheck, then divides the offset by the block
// size one quotient bit per cycle, then reads and updates the map in SFree.
// In debug mode the divide is a shift; an address out of region is reported
// straight from the region check. The map is a memory of 64-bit words, so
// reset runs a clearing pass over every word during which busy_o is high;
// configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i are taken any
// time and must happen only while the block is idle.
module bitmap_slab_allocator import bsa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 1024,
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned ADDR_BITS  = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  req_t                   req_i,
  output logic                   busy_o,
  output logic                   done_o,
  output rsp_t                   rsp_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned Words   = (MAX_BLOCKS + 63) / 64;
  localparam int unsigned WBits   = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned IdxBits = $clog2(MAX_BLOCKS) + 1;
  localparam int unsigned ABits   = ADDR_BITS;
  localparam int unsigned PgShift = $clog2(PAGE_BYTES);

  // Configuration registers.
  logic [12:0]      bsize_q;
  logic [10:0]      bcount_q;
  logic [47:0]      rbase_q, rlen_q, dbase_q;
  logic             dbg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= 13'd64;
      bcount_q <= 11'd1024;
      rbase_q  <= '0;
      rlen_q   <= '0;
      dbg_q    <= 1'b0;
      dbase_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBlockSize:    bsize_q  <= cfg_data_i[12:0];
        RegBlockCount:   bcount_q <= cfg_data_i[10:0];
        RegRegionBase:   rbase_q  <= cfg_data_i;
        RegRegionLength: rlen_q   <= cfg_data_i;
        RegDebugMode:    dbg_q    <= cfg_data_i[0];
        RegDebugBase:    dbase_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [12:0]        esize;
  logic [IdxBits-1:0] ecount;
  assign esize  = (bsize_q == '0) ? 13'd1 : bsize_q;
  assign ecount = (32'(bcount_q) > MAX_BLOCKS) ? IdxBits'(MAX_BLOCKS) : IdxBits'(bcount_q);

  // Used map memory.
  logic [63:0]      map_mem [Words];
  logic             mem_we;
  logic [WBits-1:0] mem_waddr, mem_raddr;
  logic [63:0]      mem_wdata, mem_rdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= map_mem[mem_raddr];
  end

  state_e             state_q, state_d;
  logic               clr_q, clr_d;
  logic [WBits:0]     wptr_q, wptr_d;
  logic               rdv_q, rdv_d;
  logic               mode_q, mode_d;
  logic [IdxBits-1:0] idx_q, idx_d;
  logic [ABits-1:0]   prod_q, prod_d;
  logic [1:0]         st_q, st_d;
  logic [47:0]        addr_q, addr_d;
  logic               done_q, done_d;

  // Priority encoder on the inverted word, masked to the configured block count.
  logic [63:0] freem;
  logic        found;
  logic [5:0]  fpos;
  logic [IdxBits+5:0] gidx;
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    gidx  = '0;
    for (int b = 63; b >= 0; b--) begin
      gidx = (IdxBits+6)'({wptr_q - 1'b1, 6'(b)});
      freem[b] = ~mem_rdata[b] && (gidx < (IdxBits+6)'(ecount));
      if (freem[b]) begin
        found = 1'b1;
        fpos  = 6'(b);
      end
    end
  end

  // Block index times block size; both operands are narrow.
  logic [IdxBits+12:0] mul_res;
  assign mul_res = (IdxBits+13)'(idx_q) * (IdxBits+13)'(esize);

  // Region check for a free.
  logic [ABits-1:0] where, fbase, flen, foff;
  logic             in_range;
  assign where = ABits'(req_i.free_address);
  assign fbase = dbg_q ? ABits'(dbase_q) : ABits'(rbase_q);
  assign flen  = dbg_q ? (ABits'(bcount_q) << (PgShift + 1)) : ABits'(rlen_q);

  logic [ABits-1:0] wq;
  logic [ABits-1:0] divq;
  logic             div_start, div_done;

  // The divider takes the offset at the edge that ends the region check.
  bsa_divider #(.NumBits(ABits), .DenBits(13)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (foff),
    .den_i  (esize),
    .done_o (div_done),
    .quot_o (divq)
  );

  assign wq = addr_q;  // holds the free address during the region check

  always_comb begin
    foff     = wq - fbase;
    in_range = (wq >= fbase) && (foff <= flen) && (ABits'(esize) <= flen - foff);
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    wptr_d    = wptr_q;
    rdv_d     = 1'b0;
    mode_d    = mode_q;
    idx_d     = idx_q;
    prod_d    = prod_q;
    st_d      = st_q;
    addr_d    = addr_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wptr_q[WBits-1:0];
    mem_wdata = '0;
    mem_raddr = wptr_q[WBits-1:0];
    div_start = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (clr_q) begin
          mem_we = 1'b1;
          wptr_d = wptr_q + 1'b1;
          if (32'(wptr_q) == Words - 1) begin
            clr_d  = 1'b0;
            wptr_d = '0;
          end
        end else if (start_i) begin
          mode_d = req_i.mode;
          addr_d = 48'(where);
          wptr_d = '0;
          state_d = req_i.mode ? SCheck : SScan;
        end
      end
      SScan: begin
        // Read issued for word wptr_q; its data is checked in the next cycle.
        mem_raddr = wptr_q[WBits-1:0];
        if (rdv_q && found) begin
          idx_d   = IdxBits'((wptr_q - 1'b1) * 64) + IdxBits'(fpos);
          mem_we    = 1'b1;
          mem_waddr = WBits'(wptr_q - 1'b1);
          mem_wdata = mem_rdata | (64'd1 << fpos);
          state_d = SMul;
        end else if (rdv_q && 32'(wptr_q) >= Words) begin
          st_d    = StNone;
          addr_d  = '0;
          state_d = SDone;
        end else begin
          rdv_d  = 1'b1;
          wptr_d = wptr_q + 1'b1;
        end
      end
      SMul: begin
        prod_d  = dbg_q ? (ABits'(idx_q) << (PgShift + 1))
                        : ABits'(mul_res);
        state_d = SAddr;
      end
      SAddr: begin
        if (dbg_q) addr_d = 48'(ABits'(dbase_q) + prod_q + ABits'(PAGE_BYTES) - ABits'(esize));
        else       addr_d = 48'(ABits'(rbase_q) + prod_q);
        st_d    = StOk;
        state_d = SDone;
      end
      SCheck: begin
        addr_d = '0;
        if (!in_range) begin
          st_d    = StRange;
          state_d = SDone;
        end else if (dbg_q) begin
          prod_d  = foff >> (PgShift + 1);
          state_d = SFree;
          rdv_d   = 1'b0;
        end else begin
          div_start = 1'b1;
          state_d = SDiv;
        end
      end
      SDiv: begin
        if (div_done) begin
          prod_d  = divq;
          state_d = SFree;
        end
      end
      SFree: begin
        mem_raddr = WBits'(prod_q >> 6);
        if (!rdv_q) begin
          if (prod_q >= ABits'(ecount)) begin
            st_d    = StFreed;
            state_d = SDone;
          end else begin
            rdv_d = 1'b1;
          end
        end else if (!mem_rdata[prod_q[5:0]]) begin
          st_d    = StFreed;
          state_d = SDone;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = WBits'(prod_q >> 6);
          mem_wdata = mem_rdata & ~(64'd1 << prod_q[5:0]);
          st_d      = StOk;
          state_d   = SDone;
        end
      end
      SDone: begin
        done_d  = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      clr_q   <= 1'b1;
      wptr_q  <= '0;
      rdv_q   <= 1'b0;
      done_q  <= 1'b0;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wptr_q  <= wptr_d;
      rdv_q   <= rdv_d;
      done_q  <= done_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    prod_q <= prod_d;
    st_q   <= st_d;
    addr_q <= addr_d;
  end

  assign busy_o = clr_q || (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o.status        = st_q;
  assign rsp_o.block_address = (st_q == StOk && !mode_q) ? addr_q : '0;

endmodule

// ===== rtl/bsa_divider.sv =====
// Restoring divider: one quotient bit per cycle.
module bsa_divider import bsa_pkg::*; #(
  parameter int unsigned NumBits = 48,
  parameter int unsigned DenBits = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits-1:0] rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DenBits'(trial - {1'b0, den_q});
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d  = trial[DenBits-1:0];
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== tb/sv/tb_bitmap_slab_allocator.sv =====
module tb_bitmap_slab_allocator;
  import bsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned PageBytes = 4096;
  localparam longint unsigned Mask48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam int unsigned DrainCycles = 80;
  localparam longint unsigned CycleLimit = 1_500_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  req_t                   req_i;
  logic                   busy_o;
  logic                   done_o;
  rsp_t                   rsp_o;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  bitmap_slab_allocator u_top (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Mirror of the block's registers and used map.
  logic [12:0]          m_size;
  logic [10:0]          m_count;
  logic [47:0]          m_rbase;
  logic [47:0]          m_rlen;
  logic                 m_dbg;
  logic [47:0]          m_dbase;
  logic [MaxBlocks-1:0] used_map;

  req_t req_backlog_q[$];
  rsp_t pending_rsp_q[$];
  int unsigned mismatches;
  longint unsigned cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  logic hold_sender;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned eff_size();
    return (m_size == 0) ? 64'd1 : 64'(m_size);
  endfunction

  function automatic longint unsigned eff_count();
    return (m_count > MaxBlocks) ? 64'(MaxBlocks) : 64'(m_count);
  endfunction

  function automatic rsp_t allocator_predict(req_t r);
    rsp_t o;
    longint unsigned base, len, off, idx, where;
    o.status = StNone;
    o.block_address = '0;
    if (r.mode == 1'b0) begin
      for (int unsigned i = 0; i < eff_count(); i++) begin
        if (!used_map[i]) begin
          used_map[i] = 1'b1;
          if (m_dbg)
            o.block_address = 48'((64'(m_dbase) + 64'(i) * 2 * PageBytes + PageBytes
                                   - eff_size()) & Mask48);
          else
            o.block_address = 48'((64'(m_rbase) + 64'(i) * eff_size()) & Mask48);
          o.status = StOk;
          break;
        end
      end
    end else begin
      where = 64'(r.free_address);
      base = m_dbg ? 64'(m_dbase) : 64'(m_rbase);
      len = m_dbg ? 64'(m_count) * 2 * PageBytes : 64'(m_rlen);
      if (where < base) begin
        o.status = StRange;
      end else begin
        off = where - base;
        if (off > len || eff_size() > len - off) begin
          o.status = StRange;
        end else begin
          idx = m_dbg ? off / (2 * PageBytes) : off / eff_size();
          if (idx >= eff_count() || !used_map[idx[9:0]]) begin
            o.status = StFreed;
          end else begin
            used_map[idx[9:0]] = 1'b0;
            o.status = StOk;
          end
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    mismatches++;
  endtask

  // Sender: bursts of requests separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      logic accepted;
      accepted = start_i && !busy_o;
      if (accepted) begin
        pending_rsp_q.push_back(allocator_predict(req_backlog_q.pop_front()));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (req_backlog_q.size() > 0 && !hold_sender) begin
        start_i <= 1'b1;
        req_i <= req_backlog_q[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Results cannot be held off, so every strobe is checked in its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected request result", rsp_o, 0);
      end else begin
        rsp_t want;
        want = pending_rsp_q.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch("status", rsp_o.status, want.status);
        if (rsp_o.block_address !== want.block_address)
          report_mismatch("block_address", rsp_o.block_address, want.block_address);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, longint unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[47:0];
    case (idx)
      RegBlockSize:    m_size = val[12:0];
      RegBlockCount:   m_count = val[10:0];
      RegRegionBase:   m_rbase = val[47:0];
      RegRegionLength: m_rlen = val[47:0];
      RegDebugMode:    m_dbg = val[0];
      RegDebugBase:    m_dbase = val[47:0];
      default: ;
    endcase
  endtask

  task automatic configure(longint unsigned size, longint unsigned count,
                           longint unsigned rbase, longint unsigned rlen,
                           longint unsigned dbg, longint unsigned dbase);
    write_reg(RegBlockSize, size);
    write_reg(RegBlockCount, count);
    write_reg(RegRegionBase, rbase);
    write_reg(RegRegionLength, rlen);
    write_reg(RegDebugMode, dbg);
    write_reg(RegDebugBase, dbase);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // The sender works off the backlog until every result is back, then the block gets time to settle.
  task automatic drain();
    hold_sender = 1'b1;
    wait (req_backlog_q.size() == 0 || hold_sender);
    while (req_backlog_q.size() > 0 || pending_rsp_q.size() > 0 || start_i || busy_o) begin
      hold_sender = (req_backlog_q.size() == 0) ? 1'b1 : 1'b0;
      @(posedge clk_i);
    end
    hold_sender = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic req_t make_free(longint unsigned where);
    req_t r;
    r.mode = 1'b1;
    r.free_address = where[47:0];
    return r;
  endfunction

  function automatic req_t make_alloc();
    req_t r;
    r.mode = 1'b0;
    r.free_address = 48'({$urandom, $urandom});
    return r;
  endfunction

  // Allocations at alloc_pct percent; frees mostly land on real blocks, some off by a little, some anywhere.
  function automatic req_t random_request(int unsigned alloc_pct);
    longint unsigned base, stride, idx, where;
    if ($urandom_range(0, 99) < alloc_pct) return make_alloc();
    base = m_dbg ? 64'(m_dbase) : 64'(m_rbase);
    stride = m_dbg ? 2 * PageBytes : eff_size();
    idx = $urandom_range(0, int'(eff_count()) + 2);
    where = base + idx * stride;
    case ($urandom_range(0, 9))
      0: where = {$urandom, $urandom};
      1: where = where + $urandom_range(0, int'(stride) - 1);
      2: where = where - $urandom_range(1, 3);
      default: ;
    endcase
    return make_free(where & Mask48);
  endfunction

  task automatic random_phase(longint unsigned size, longint unsigned count,
                              longint unsigned rbase, longint unsigned rlen,
                              longint unsigned dbg, longint unsigned dbase,
                              int unsigned n, int unsigned alloc_pct);
    configure(size, count, rbase, rlen, dbg, dbase);
    for (int unsigned k = 0; k < n; k++) req_backlog_q.push_back(random_request(alloc_pct));
    hold_sender = 1'b0;
    drain();
  endtask

  initial begin
    longint unsigned top;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegBlockSize;
    cfg_data_i = '0;
    mismatches = 0;
    cycles = 0;
    burst_left = 1;
    gap_left = 0;
    hold_sender = 1'b1;
    used_map = '0;
    m_size = 13'd64;
    m_count = 11'd1024;
    m_rbase = '0;
    m_rlen = '0;
    m_dbg = 1'b0;
    m_dbase = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // Reset values: region length zero, so every free is out of region.
    req_backlog_q.push_back(make_alloc());
    req_backlog_q.push_back(make_alloc());
    req_backlog_q.push_back(make_free(0));
    hold_sender = 1'b0;
    drain();

    // Zero block size acts as one, a base near the top wraps, count runs out.
    top = 48'hFFFF_FFFF_FFFE;
    configure(0, 4, top, 16, 0, 0);
    repeat (5) req_backlog_q.push_back(make_alloc());
    req_backlog_q.push_back(make_free(top));
    req_backlog_q.push_back(make_free(top));
    req_backlog_q.push_back(make_free(top + 5));
    req_backlog_q.push_back(make_free(top - 1));
    req_backlog_q.push_back(make_free(top + 16));
    req_backlog_q.push_back(make_free(0));
    req_backlog_q.push_back(make_free(Mask48));
    hold_sender = 1'b0;
    drain();

    // Debug layout at the very top of the address space, and zero block count.
    configure(4096, 3, 0, 0, 1, 48'hFFFF_FFFF_C000);
    repeat (4) req_backlog_q.push_back(make_alloc());
    req_backlog_q.push_back(make_free(48'hFFFF_FFFF_C000 + 8192 + 100));
    req_backlog_q.push_back(make_free(48'hFFFF_FFFF_C000 + 8192));
    req_backlog_q.push_back(make_free(48'hFFFF_FFFF_BFFF));
    hold_sender = 1'b0;
    drain();
    configure(64, 0, 0, 64, 0, 0);
    req_backlog_q.push_back(make_alloc());
    req_backlog_q.push_back(make_free(0));
    hold_sender = 1'b0;
    drain();

    random_phase(64, 1024, 48'h1000, 1024 * 64, 0, 0, 300, 60);
    random_phase(1, 1, 0, 16, 0, 0, 120, 50);
    random_phase(4096, 2047, 48'hFFFF_FFFF_0000, Mask48, 0, 0, 250, 55);
    random_phase(0, 8, 48'h1_2345_6789, 64, 0, 0, 150, 50);
    random_phase(8191, 30, 48'h8000_0000_0000, 30 * 8191, 0, 0, 180, 55);
    random_phase(100, 20, 0, 0, 1, 48'hFFFF_FFFF_C000, 200, 50);
    random_phase(3, 700, 48'hABCDE, 2100, 1, 48'h1000_0000, 250, 55);
    random_phase(1, 1024, 0, 1024, 0, 0, 200, 50);
    random_phase(4096, 12, 48'h5555_5555_5000, 12 * 4096 + 7, 1, 48'hAAAA_AAAA_A000, 150, 45);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
